// ===== hw/rtl/lfo_envelope_modulator_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef LFO_ENVELOPE_MODULATOR_DEFINES_SVH
`define LFO_ENVELOPE_MODULATOR_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define LEM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lem check failed");

// Checks that an implication's consequent holds in the cycle after its condition.
`define LEM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lem check failed");

`endif

// ===== hw/rtl/lem_pkg.sv =====
// ----------------------------------------------------------------------------
// lem_pkg
// Shared constants, types and tables for the LFO and envelope modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package lem_pkg;

    localparam int SLOTS_DEF = 8;
    localparam logic [16:0] ONE_Q15  = 17'd32768;
    localparam logic [16:0] HALF_Q15 = 17'd16384;
    localparam logic [16:0] ENV_STEP = 17'd3277;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_LFO = 2'd1;
    localparam logic [1:0] MODE_ENV = 2'd2;

    localparam logic [2:0] WAVE_SINE = 3'd0;
    localparam logic [2:0] WAVE_SQR  = 3'd1;
    localparam logic [2:0] WAVE_SAW  = 3'd2;
    localparam logic [2:0] WAVE_TRI  = 3'd3;

    localparam logic [2:0] CURVE_LIN  = 3'd0;
    localparam logic [2:0] CURVE_SQR  = 3'd1;
    localparam logic [2:0] CURVE_SQRT = 3'd2;
    localparam logic [2:0] CURVE_SIG  = 3'd3;
    localparam logic [2:0] CURVE_SINE = 3'd4;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_WAVE    = 3'd1;
    localparam logic [2:0] REG_INC     = 3'd2;
    localparam logic [2:0] REG_AMOUNT  = 3'd3;
    localparam logic [2:0] REG_ATTACK  = 3'd4;
    localparam logic [2:0] REG_DECAY   = 3'd5;
    localparam logic [2:0] REG_SUSTAIN = 3'd6;
    localparam logic [2:0] REG_CURVE   = 3'd7;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_LOAD   = 4'd0;  // fetch phase, clamp, form level source
    localparam logic [3:0] OP_SINE_A = 4'd1;  // t2 = t*t
    localparam logic [3:0] OP_SINE_B = 4'd2;  // t4 = t2*t2, c1 = 21024*t2
    localparam logic [3:0] OP_SINE_C = 4'd3;  // c2 = 2320*t4
    localparam logic [3:0] OP_SINE_D = 4'd4;  // s = t*poly, finish level
    localparam logic [3:0] OP_DIV    = 4'd5;  // one restoring division step
    localparam logic [3:0] OP_ENV_M  = 4'd6;  // decay product
    localparam logic [3:0] OP_SQR    = 4'd7;  // square curve
    localparam logic [3:0] OP_SQRT   = 4'd8;  // one square root step
    localparam logic [3:0] OP_SIG    = 4'd9;  // sigmoid interpolation
    localparam logic [3:0] OP_MOD    = 4'd10; // modulation product and clamp
    localparam logic [3:0] OP_DIVINI = 4'd11; // set up the divider
    localparam logic [3:0] OP_ENVEND = 4'd12; // finish envelope level
    localparam logic [3:0] OP_SQRINI = 4'd13; // set up the square root
    localparam logic [3:0] OP_CURVE  = 4'd14; // pick level for curve stage
    localparam logic [3:0] OP_NOP    = 4'd15;

    typedef struct packed {
        logic       start;
        logic [3:0] op;
        logic       sine_curve; // sine pass serves the curve, not the wave
    } t_cmd;

    typedef struct packed {
        logic [1:0] env_seg;   // 0 attack, 1 decay, 2 sustain
        logic       pass;
    } t_stat;

    typedef logic [16:0] t_sig_tab [0:8];
    localparam t_sig_tab SIG_TABLE = '{
        17'd16384, 17'd19421, 17'd22255, 17'd24737, 17'd26790,
        17'd28411, 17'd29644, 17'd30555, 17'd31214
    };

endpackage

`default_nettype wire

// ===== hw/rtl/lem_ctrl.sv =====
// ----------------------------------------------------------------------------
// lem_ctrl
// Sequencer that steps the datapath through one item's operations.
// ----------------------------------------------------------------------------
`default_nettype none

module lem_ctrl
    import lem_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [1:0] i_mode,
    input  wire logic [2:0] i_wave,
    input  wire logic [2:0] i_curve,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SINE  = 4'd2;
    localparam logic [3:0] S_DINI  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_ENVM  = 4'd5;
    localparam logic [3:0] S_ENVE  = 4'd6;
    localparam logic [3:0] S_CURVE = 4'd7;
    localparam logic [3:0] S_SQR   = 4'd8;
    localparam logic [3:0] S_QINI  = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_SIG   = 4'd11;
    localparam logic [3:0] S_MOD   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_sine_curve, n_sine_curve;
    logic       accept;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_sine_curve = r_sine_curve;
        o_cmd.start      = accept;
        o_cmd.op         = OP_NOP;
        o_cmd.sine_curve = r_sine_curve;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_cnt = 5'd0;
                n_sine_curve = 1'b0;
                if (i_stat.pass) begin
                    n_state = S_OUT;
                end else if (i_mode == MODE_LFO) begin
                    n_state = (i_wave == WAVE_SINE) ? S_SINE : S_CURVE;
                end else begin
                    n_state = S_DINI;
                end
            end
            S_SINE: begin
                unique case (r_cnt[1:0])
                    2'd0:    o_cmd.op = OP_SINE_A;
                    2'd1:    o_cmd.op = OP_SINE_B;
                    2'd2:    o_cmd.op = OP_SINE_C;
                    default: o_cmd.op = OP_SINE_D;
                endcase
                n_cnt = r_cnt + 5'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt = 5'd0;
                    n_state = r_sine_curve ? S_MOD : S_CURVE;
                end
            end
            S_DINI: begin
                // The envelope segment is known in the cycle after the phase fetch.
                n_cnt = 5'd0;
                if (i_stat.env_seg == 2'd2) begin
                    n_state = S_CURVE;
                end else begin
                    o_cmd.op = OP_DIVINI;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd14) begin
                    n_state = (i_stat.env_seg == 2'd1) ? S_ENVM : S_ENVE;
                end
            end
            S_ENVM: begin
                o_cmd.op = OP_ENV_M;
                n_state = S_ENVE;
            end
            S_ENVE: begin
                o_cmd.op = OP_ENVEND;
                n_state = S_CURVE;
            end
            S_CURVE: begin
                o_cmd.op = OP_CURVE;
                n_cnt = 5'd0;
                unique case (i_curve)
                    CURVE_SQR:  n_state = S_SQR;
                    CURVE_SQRT: n_state = S_QINI;
                    CURVE_SIG:  n_state = S_SIG;
                    CURVE_SINE: begin
                        n_state = S_SINE;
                        n_sine_curve = 1'b1;
                    end
                    default:    n_state = S_MOD;
                endcase
            end
            S_SQR: begin
                o_cmd.op = OP_SQR;
                n_state = S_MOD;
            end
            S_QINI: begin
                o_cmd.op = OP_SQRINI;
                n_cnt = 5'd0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_state = S_MOD;
                end
            end
            S_SIG: begin
                o_cmd.op = OP_SIG;
                n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.op = OP_MOD;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= 5'd0;
            r_sine_curve <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_sine_curve <= n_sine_curve;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lem_dp.sv =====
// ----------------------------------------------------------------------------
// lem_dp
// Datapath: phase store, wave and envelope levels, shared divider and
// square root, curve shaping and the final modulation.
// ----------------------------------------------------------------------------
`default_nettype none

module lem_dp
    import lem_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [2:0]  i_slot,
    input  wire logic [15:0] i_current_level,
    input  wire logic [1:0]  i_mode,
    input  wire logic [2:0]  i_wave,
    input  wire logic [15:0] i_inc,
    input  wire logic [15:0] i_amount,
    input  wire logic [15:0] i_attack,
    input  wire logic [15:0] i_decay,
    input  wire logic [15:0] i_sustain,
    output logic [15:0]      o_result_level,
    output logic [15:0]      o_shaped_level
);

    // The slot field is 3 bits wide, so at most eight phases are reachable.
    localparam int NPH = (SLOTS < 8) ? SLOTS : 8;
    localparam int SW  = (NPH > 1) ? $clog2(NPH) : 1;

    logic [15:0] r_phase [NPH];
    logic [2:0]  r_slot;
    logic [15:0] r_cur;
    logic        r_pass;
    logic [1:0]  r_seg;
    logic [16:0] r_p;
    logic [16:0] r_lvl;      // level before curve, later shaped level
    logic [16:0] r_t;        // sine argument
    logic [1:0]  r_q;        // sine quadrant
    logic [16:0] r_t2, r_t4, r_c1, r_c2;
    logic [31:0] r_rem;      // divider remainder / sqrt radicand
    logic [16:0] r_quo;      // divider quotient
    logic [31:0] r_root;     // square root partial result
    logic [16:0] r_div;
    logic [31:0] r_bit;
    logic [16:0] r_a, r_d, r_s;
    logic [15:0] r_result;

    logic          slot_ok;
    logic [SW-1:0] ph_idx;
    logic [16:0]   ph_clamp, inc_c, np_lfo, np_env, a_eff, d_eff, s_eff;
    logic [17:0]   ad_sum;

    assign slot_ok = ({6'd0, i_slot} < 9'(SLOTS));
    assign ph_idx  = SW'(r_slot);
    assign o_stat.pass    = r_pass;
    assign o_stat.env_seg = r_seg;
    assign o_result_level = r_result;
    assign o_shaped_level = r_lvl[15:0];

    always_comb begin
        ph_clamp = 17'(r_phase[ph_idx]);
        if (ph_clamp > ONE_Q15) ph_clamp = ONE_Q15;
        inc_c = (17'(i_inc) > ONE_Q15) ? ONE_Q15 : 17'(i_inc);
        np_lfo = ph_clamp + inc_c;
        if (np_lfo > ONE_Q15) np_lfo = np_lfo - ONE_Q15;
        np_env = ph_clamp;
        if (np_env < ONE_Q15) begin
            np_env = np_env + ENV_STEP;
            if (np_env > ONE_Q15) np_env = ONE_Q15;
        end
        a_eff = (i_attack == 16'd0) ? 17'd1 : 17'(i_attack);
        d_eff = (i_decay == 16'd0) ? 17'd1 : 17'(i_decay);
        s_eff = (17'(i_sustain) > ONE_Q15) ? ONE_Q15 : 17'(i_sustain);
        ad_sum = 18'(a_eff) + 18'(d_eff);
    end

    // Sine helpers
    logic [16:0] sine_x, sine_r;
    logic [33:0] m_t2, m_t4, m_c1, m_c2, m_s;
    logic [16:0] poly, s_val;
    always_comb begin
        sine_x = i_cmd.sine_curve ? r_lvl : r_p;
        sine_r = {2'b0, sine_x[12:0], 2'b0};
        if (sine_x[13]) sine_r = ONE_Q15 - sine_r;
        m_t2 = 34'(r_t) * 34'(r_t);
        m_t4 = 34'(r_t2) * 34'(r_t2);
        m_c1 = 34'd21024 * 34'(r_t2);
        m_c2 = 34'd2320 * 34'(r_t4);
        poly = 17'(18'd51472 - 18'(r_c1) + 18'(r_c2));
        m_s  = 34'(r_t) * 34'(poly);
        s_val = 17'(m_s >> 15);
    end

    // Divider step: quotient of (num << 15) / den, 15 bits.
    logic [32:0] div_try;
    assign div_try = {r_rem, 1'b0} - {16'd0, r_div};

    // Square root step over a 31-bit radicand.
    logic [31:0] sq_sum;
    assign sq_sum = r_root + r_bit;

    // Sigmoid
    logic [16:0] sg_d, sg_v, sg_lo, sg_hi;
    logic [3:0]  sg_k;
    logic [28:0] sg_m;
    always_comb begin
        sg_d = (r_lvl >= HALF_Q15) ? r_lvl - HALF_Q15 : HALF_Q15 - r_lvl;
        sg_k = (sg_d[16:11] >= 6'd8) ? 4'd8 : sg_d[14:11];
        sg_lo = SIG_TABLE[sg_k];
        sg_hi = (sg_k == 4'd8) ? sg_lo : SIG_TABLE[sg_k + 4'd1];
        sg_m = 29'(sg_hi - sg_lo) * 29'(sg_d[10:0]);
        sg_v = (sg_k == 4'd8) ? sg_lo : sg_lo + 17'(sg_m >> 11);
    end

    // Modulation
    logic [16:0] md_d;
    logic [32:0] md_m;
    logic [18:0] md_sum;
    always_comb begin
        md_d = (r_lvl >= HALF_Q15) ? r_lvl - HALF_Q15 : HALF_Q15 - r_lvl;
        md_m = 33'(md_d) * 33'(i_amount);
        if (r_lvl >= HALF_Q15) begin
            md_sum = 19'(r_cur) + 19'(md_m >> 14);
        end else begin
            md_sum = 19'(r_cur) - 19'(md_m >> 14);
        end
    end

    logic [33:0] m_env, m_sq;
    assign m_env = 34'(r_quo) * 34'(ONE_Q15 - r_s);
    assign m_sq  = 34'(r_lvl) * 34'(r_lvl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPH; i++) r_phase[i] <= 16'd0;
            r_pass <= 1'b1;
            r_seg  <= 2'd0;
        end else begin
            if (i_cmd.start) begin
                r_slot <= i_slot;
                r_cur  <= i_current_level;
                r_pass <= !((i_mode == MODE_LFO) || (i_mode == MODE_ENV)) || !slot_ok;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_p <= ph_clamp;
                    r_a <= a_eff;
                    r_d <= d_eff;
                    r_s <= s_eff;
                    if (r_pass) begin
                        r_result <= r_cur;
                        r_lvl    <= 17'd0;
                    end else if (i_mode == MODE_LFO) begin
                        r_phase[ph_idx] <= np_lfo[15:0];
                        unique case (i_wave)
                            WAVE_SQR: r_lvl <= (ph_clamp < HALF_Q15) ? ONE_Q15 : 17'd0;
                            WAVE_SAW: r_lvl <= ph_clamp;
                            WAVE_TRI: r_lvl <= (ph_clamp < HALF_Q15) ?
                                17'(ph_clamp << 1) : 17'((ONE_Q15 - ph_clamp) << 1);
                            default:  r_lvl <= HALF_Q15;
                        endcase
                    end else begin
                        r_phase[ph_idx] <= np_env[15:0];
                        if (ph_clamp < a_eff) begin
                            r_seg <= 2'd0;
                        end else if (18'(ph_clamp) < ad_sum) begin
                            r_seg <= 2'd1;
                        end else begin
                            r_seg <= 2'd2;
                            r_lvl <= s_eff;
                        end
                    end
                end
                OP_SINE_A: begin
                    r_t  <= sine_r;
                    r_q  <= sine_x[14:13];
                    r_t2 <= 17'((34'(sine_r) * 34'(sine_r)) >> 15);
                end
                OP_SINE_B: begin
                    r_t4 <= 17'(m_t4 >> 15);
                    r_c1 <= 17'(m_c1 >> 15);
                end
                OP_SINE_C: begin
                    r_c2 <= 17'(m_c2 >> 15);
                end
                OP_SINE_D: begin
                    r_lvl <= (r_q < 2'd2) ? 17'((18'(ONE_Q15) + 18'(s_val)) >> 1)
                                          : 17'((ONE_Q15 - s_val) >> 1);
                end
                OP_DIVINI: begin
                    // Numerator p (attack) or p - A (decay) is below the divisor.
                    r_rem <= (r_seg == 2'd0) ? 32'(r_p) : 32'(r_p - r_a);
                    r_div <= (r_seg == 2'd0) ? r_a : r_d;
                    r_quo <= 17'd0;
                end
                OP_DIV: begin
                    if (!div_try[32]) begin
                        r_rem <= div_try[31:0];
                        r_quo <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], 1'b0};
                        r_quo <= {r_quo[15:0], 1'b0};
                    end
                end
                OP_ENV_M: begin
                    r_quo <= ONE_Q15 - 17'(m_env >> 15);
                end
                OP_ENVEND: begin
                    r_lvl <= r_quo;
                end
                OP_SQR: begin
                    r_lvl <= 17'(m_sq >> 15);
                end
                OP_SQRINI: begin
                    r_rem  <= {r_lvl[16:0], 15'd0};
                    r_root <= 32'd0;
                    r_bit  <= 32'h4000_0000;
                end
                OP_SQRT: begin
                    if (r_rem >= sq_sum) begin
                        r_rem  <= r_rem - sq_sum;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 32'd1) begin
                        if (r_rem >= sq_sum) r_lvl <= 17'((r_root >> 1) + r_bit);
                        else r_lvl <= 17'(r_root >> 1);
                    end
                end
                OP_SIG: begin
                    r_lvl <= (r_lvl >= HALF_Q15) ? sg_v : ONE_Q15 - sg_v;
                end
                OP_MOD: begin
                    if (md_sum[18]) r_result <= 16'd0;
                    else if (md_sum > 19'(ONE_Q15)) r_result <= ONE_Q15[15:0];
                    else r_result <= md_sum[15:0];
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfo_envelope_modulator.sv =====
// Pass-through items run from the input transfer through the load state to the result
// state; an envelope decay level shaped by the square root curve takes longest, set by
// the 15-step divider and the 16-step square root, both iterative units in the datapath.
// Items are handled one at a time; the next transfer is taken in the cycle after the
// result leaves.
// Reset: synchronous, active low; clears all slot phases and loads register defaults.
`default_nettype none

`include "lfo_envelope_modulator_defines.svh"

// ----------------------------------------------------------------------------
// lfo_envelope_modulator
// Per-slot LFO and envelope parameter modulator in Q15.
// ----------------------------------------------------------------------------
module lfo_envelope_modulator
    import lem_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_slot,
    input  wire logic [15:0] i_current_level,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_result_level,
    output logic [15:0]      o_shaped_level
);

    logic [1:0]  r_mode;
    logic [2:0]  r_wave, r_curve;
    logic [15:0] r_inc, r_amount, r_attack, r_decay, r_sustain;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_wave    <= WAVE_SINE;
            r_inc     <= 16'd328;
            r_amount  <= 16'd16384;
            r_attack  <= 16'd3277;
            r_decay   <= 16'd3277;
            r_sustain <= 16'd22938;
            r_curve   <= CURVE_LIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:    r_mode    <= i_cfg_data[1:0];
                REG_WAVE:    r_wave    <= i_cfg_data[2:0];
                REG_INC:     r_inc     <= i_cfg_data;
                REG_AMOUNT:  r_amount  <= i_cfg_data;
                REG_ATTACK:  r_attack  <= i_cfg_data;
                REG_DECAY:   r_decay   <= i_cfg_data;
                REG_SUSTAIN: r_sustain <= i_cfg_data;
                default:     r_curve   <= i_cfg_data[2:0];
            endcase
        end
    end

    lem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_mode      (r_mode),
        .i_wave      (r_wave),
        .i_curve     (r_curve),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lem_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_slot          (i_slot),
        .i_current_level (i_current_level),
        .i_mode          (r_mode),
        .i_wave          (r_wave),
        .i_inc           (r_inc),
        .i_amount        (r_amount),
        .i_attack        (r_attack),
        .i_decay         (r_decay),
        .i_sustain       (r_sustain),
        .o_result_level  (o_result_level),
        .o_shaped_level  (o_shaped_level)
    );

    `LEM_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `LEM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall && !o_out_valid)
    `LEM_ASSERT_IMPL(a_result_range, i_clk, i_rst_n, o_out_valid && (o_shaped_level != 16'd0),
        o_result_level <= 16'd32768)

endmodule

`default_nettype wire

// ===== verif/tb_lfo_envelope_modulator.sv =====
`timescale 1ns / 100ps
`default_nettype none

// ----------------------------------------------------------------------------
// tb_lfo_envelope_modulator
// Drives slot/value transfers through the modulator under several register
// settings. Results are checked against a Q15 bench model of the phase store,
// wave and envelope levels and curve, or against typed-in values for fixed rows.
// ----------------------------------------------------------------------------
module tb_lfo_envelope_modulator;
    import lem_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_slot;
    logic [15:0] i_current_level;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_result_level;
    logic [15:0] o_shaped_level;

    lfo_envelope_modulator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_slot          (i_slot),
        .i_current_level (i_current_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_level  (o_result_level),
        .o_shaped_level  (o_shaped_level)
    );

    typedef struct {
        logic [15:0] result_level;
        logic [15:0] shaped_level;
    } t_mod_result;

    // Directed rows; use_fixed marks rows whose result is typed in.
    typedef struct {
        logic [2:0]  slot;
        logic [15:0] level;
        bit          use_fixed;
        logic [15:0] fixed_result;
        logic [15:0] fixed_shaped;
    } t_row;

    // Bench copy of the block state and registers.
    logic [15:0] phase_q [8];
    logic [1:0]  mode_q;
    logic [2:0]  wave_q;
    logic [15:0] inc_q, amount_q, attack_q, decay_q, sustain_q;
    logic [2:0]  curve_q;

    t_mod_result expected_q[$];
    int          error_count = 0;
    int          idle_cycles;
    bit          hold_off_req;
    bit          long_hold;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int unsigned quarter_sine(input int unsigned t);
        int unsigned t2, t4, poly;
        t2   = (t * t) >> 15;
        t4   = (t2 * t2) >> 15;
        poly = 51472 - ((21024 * t2) >> 15) + ((2320 * t4) >> 15);
        return (t * poly) >> 15;
    endfunction

    function automatic int unsigned sine_level(input int unsigned x);
        int unsigned q, r, s;
        x = x & 32767;
        q = x >> 13;
        r = (x & 8191) << 2;
        if (q[0]) r = 32768 - r;
        s = quarter_sine(r);
        return (q < 2) ? (32768 + s) >> 1 : (32768 - s) >> 1;
    endfunction

    function automatic int unsigned int_sqrt(input int unsigned v);
        int unsigned root, probe;
        root  = 0;
        probe = 1 << 30;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic int unsigned sigmoid_level(input int unsigned l);
        int unsigned d, k, v;
        d = (l >= 16384) ? l - 16384 : 16384 - l;
        k = d >> 11;
        if (k >= 8) v = SIG_TABLE[8];
        else v = SIG_TABLE[k] + (((SIG_TABLE[k + 1] - SIG_TABLE[k]) * (d & 2047)) >> 11);
        return (l >= 16384) ? v : 32768 - v;
    endfunction

    function automatic int unsigned wave_level(input int unsigned p);
        case (wave_q)
            WAVE_SINE: return sine_level(p);
            WAVE_SQR:  return (p < 16384) ? 32768 : 0;
            WAVE_SAW:  return p;
            WAVE_TRI:  return (p < 16384) ? 2 * p : 2 * (32768 - p);
            default:   return 16384;
        endcase
    endfunction

    function automatic int unsigned envelope_level(input int unsigned p);
        int unsigned a, d, s, t;
        a = (attack_q == 0) ? 1 : attack_q;
        d = (decay_q == 0) ? 1 : decay_q;
        s = (sustain_q > 32768) ? 32768 : sustain_q;
        if (p < a) return (p * 32768) / a;
        if (p < a + d) begin
            t = ((p - a) * 32768) / d;
            return 32768 - ((t * (32768 - s)) >> 15);
        end
        return s;
    endfunction

    function automatic int unsigned shape_curve(input int unsigned l);
        case (curve_q)
            CURVE_SQR:  return (l * l) >> 15;
            CURVE_SQRT: return int_sqrt(l << 15);
            CURVE_SIG:  return sigmoid_level(l);
            CURVE_SINE: return sine_level(l);
            default:    return l;
        endcase
    endfunction

    // Computes the modulated value for one transfer and advances the slot phase.
    function automatic t_mod_result modulate(input logic [2:0] slot, input logic [15:0] cur);
        t_mod_result res;
        int unsigned p, lvl, shaped, np, inc;
        longint      sum;
        if (mode_q != MODE_LFO && mode_q != MODE_ENV) begin
            res.result_level = cur;
            res.shaped_level = '0;
            return res;
        end
        p = phase_q[slot];
        if (p > 32768) p = 32768;
        if (mode_q == MODE_LFO) begin
            lvl = wave_level(p);
            inc = (inc_q > 32768) ? 32768 : inc_q;
            np  = p + inc;
            if (np > 32768) np = np - 32768;
        end else begin
            lvl = envelope_level(p);
            np  = p;
            if (np < 32768) begin
                np = np + 3277;
                if (np > 32768) np = 32768;
            end
        end
        phase_q[slot] = np[15:0];
        shaped = shape_curve(lvl);
        sum = cur;
        if (shaped >= 16384) sum = sum + ((longint'(shaped - 16384) * amount_q) >>> 14);
        else sum = sum - ((longint'(16384 - shaped) * amount_q) >>> 14);
        if (sum < 0) sum = 0;
        if (sum > 32768) sum = 32768;
        res.result_level = sum[15:0];
        res.shaped_level = shaped[15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            REG_MODE:    mode_q    = value[1:0];
            REG_WAVE:    wave_q    = value[2:0];
            REG_INC:     inc_q     = value;
            REG_AMOUNT:  amount_q  = value;
            REG_ATTACK:  attack_q  = value;
            REG_DECAY:   decay_q   = value;
            REG_SUSTAIN: sustain_q = value;
            default:     curve_q   = value[2:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // Offers one transfer and records its expectation at the accepting edge.
    // Valid stays high after the transfer until the next gap or the next idle wait.
    task automatic send_item(input logic [2:0] slot, input logic [15:0] level,
                             input bit use_fixed, input t_mod_result fixed, input bit gaps);
        t_mod_result exp_res;
        int          gap;
        gap = gaps ? gap_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_slot          <= slot;
        i_current_level <= level;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        exp_res = modulate(slot, level);
        if (use_fixed) exp_res = fixed;
        expected_q.insert(expected_q.size(), exp_res);
    endtask

    task automatic run_random(input int count);
        t_mod_result none;
        logic [15:0] level;
        none = '{default: '0};
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0:       level = 16'($urandom());
                1:       level = $urandom_range(0, 1) ? 16'd32768 : 16'd0;
                default: level = 16'($urandom_range(0, 32768));
            endcase
            send_item(3'($urandom_range(0, 7)), level, 1'b0, none, 1'b1);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (long_hold) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 3) == 0) ? (gap_length() > 2) : 1'b0;
        end
    end

    initial begin
        long_hold = 1'b0;
        wait (hold_off_req);
        long_hold = 1'b1;
        repeat (200) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_mod_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result_level", o_result_level, 16'd0);
            end else begin
                want = expected_q.pop_front();
                if (o_result_level !== want.result_level)
                    report_mismatch("result_level", o_result_level, want.result_level);
                if (o_shaped_level !== want.shaped_level)
                    report_mismatch("shaped_level", o_shaped_level, want.shaped_level);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row        rows[3];
        t_mod_result fixed;
        hold_off_req    = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_MODE;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_slot          = '0;
        i_current_level = '0;
        foreach (phase_q[k]) phase_q[k] = '0;
        mode_q = MODE_OFF; wave_q = WAVE_SINE; inc_q = 16'd328; amount_q = 16'd16384;
        attack_q = 16'd3277; decay_q = 16'd3277; sustain_q = 16'd22938; curve_q = CURVE_LIN;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pass-through after reset gives the value back unchanged, oversized too.
        rows[0] = '{3'd0, 16'd0,     1'b1, 16'd0,     16'd0};
        rows[1] = '{3'd7, 16'd32768, 1'b1, 16'd32768, 16'd0};
        rows[2] = '{3'd3, 16'hFFFF,  1'b1, 16'hFFFF,  16'd0};
        foreach (rows[r]) begin
            fixed = '{rows[r].fixed_result, rows[r].fixed_shaped};
            send_item(rows[r].slot, rows[r].level, rows[r].use_fixed, fixed, 1'b0);
        end
        wait_idle();

        // Phase 0 triangle with full depth: level 0 drives the sum to zero.
        write_reg(REG_MODE, {14'd0, MODE_LFO});
        write_reg(REG_WAVE, {13'd0, WAVE_TRI});
        write_reg(REG_AMOUNT, 16'd32768);
        fixed = '{16'd0, 16'd0};
        send_item(3'd0, 16'd16384, 1'b1, fixed, 1'b0);
        wait_idle();

        // Every wave and every curve code, including the unused ones.
        for (int w = 0; w < 8; w++) begin
            write_reg(REG_WAVE, w[15:0]);
            write_reg(REG_CURVE, w[15:0]);
            write_reg(REG_INC, (w == 7) ? 16'hFFFF : 16'(4100 * w));
            for (int n = 0; n < 3; n++)
                send_item(w[2:0], (n == 0) ? 16'h0000 : 16'd32768, 1'b0, fixed, 1'b0);
            wait_idle();
        end

        // Envelope with zero segment lengths and oversized sustain.
        write_reg(REG_MODE, {14'd0, MODE_ENV});
        write_reg(REG_ATTACK, 16'd0);
        write_reg(REG_DECAY, 16'd0);
        write_reg(REG_SUSTAIN, 16'hFFFF);
        write_reg(REG_CURVE, {13'd0, CURVE_SQRT});
        for (int n = 0; n < 4; n++) send_item(3'd5, 16'd20000, 1'b0, fixed, 1'b0);
        wait_idle();
        write_reg(REG_MODE, 16'd3);
        send_item(3'd5, 16'd1234, 1'b0, fixed, 1'b0);
        wait_idle();

        // Random phases, each under fresh random registers.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_MODE, (ph % 4 == 3) ? 16'(ph % 2 ? 3 : 0) : 16'(1 + ph % 2));
            write_reg(REG_WAVE, 16'($urandom_range(0, 7)));
            write_reg(REG_INC, (ph == 2) ? 16'hFFFF : 16'($urandom_range(0, 32768)));
            write_reg(REG_AMOUNT, (ph == 4) ? 16'd0 : 16'($urandom_range(0, 65535)));
            write_reg(REG_ATTACK, (ph == 5) ? 16'd32768 : 16'($urandom_range(1, 12000)));
            write_reg(REG_DECAY, (ph == 6) ? 16'd32768 : 16'($urandom_range(1, 12000)));
            write_reg(REG_SUSTAIN, 16'($urandom_range(0, 65535)));
            write_reg(REG_CURVE, 16'($urandom_range(0, 7)));
            if (ph == 3) hold_off_req = 1'b1;
            run_random(60);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lem_pkg.sv
hw/rtl/lem_ctrl.sv
hw/rtl/lem_dp.sv
hw/rtl/lfo_envelope_modulator.sv
verif/tb_lfo_envelope_modulator.sv
